/* rtl/dds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_pkg: shared definitions for the decimal digit substitution block
// Widths, register indexes, opcodes, state type, cell control bundle and the
// digit table lookup.
// ----------------------------------------------------------------------------
package dds_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 64;
    localparam int DATA_W              = 64;
    localparam int DIGIT_W             = 4;
    localparam int TABLE_W             = 40;
    localparam int CFG_INDEX_W         = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_ENCODE_TABLE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_DECODE_TABLE = 1'b1;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic [TABLE_W-1:0] TABLE_RESET = 40'h98_7654_3210;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_COMB,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic clear;
        logic shift_bit;
        logic shift_digit;
    } cell_ctrl_t;

    // decimal digits needed to hold any unsigned number of the given width
    function automatic int digit_count(input int width);
        return ((width * 1233) >> 12) + 1;
    endfunction

    function automatic logic [DIGIT_W-1:0] table_digit(
        input logic [TABLE_W-1:0] tbl,
        input logic [DIGIT_W-1:0] d
    );
        logic [DIGIT_W-1:0] nib;
        unique case (d)
            4'd0:    nib = tbl[3:0];
            4'd1:    nib = tbl[7:4];
            4'd2:    nib = tbl[11:8];
            4'd3:    nib = tbl[15:12];
            4'd4:    nib = tbl[19:16];
            4'd5:    nib = tbl[23:20];
            4'd6:    nib = tbl[27:24];
            4'd7:    nib = tbl[31:28];
            4'd8:    nib = tbl[35:32];
            4'd9:    nib = tbl[39:36];
            default: nib = '0;
        endcase
        return nib;
    endfunction

endpackage

/* rtl/dds_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_cell: one decimal digit of the conversion chain
// Shift-and-add-3 step for binary to BCD, or plain digit shift toward the
// most significant end during recombination.
// ----------------------------------------------------------------------------
module dds_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dds_pkg::cell_ctrl_t            ctrl,
    input  logic                           bit_in,
    output logic                           bit_out,
    input  logic [dds_pkg::DIGIT_W-1:0]    digit_in,
    output logic [dds_pkg::DIGIT_W-1:0]    digit
);

    logic [dds_pkg::DIGIT_W-1:0] digit_reg;
    logic [dds_pkg::DIGIT_W-1:0] digit_next;
    logic [dds_pkg::DIGIT_W-1:0] adj;

    always_comb
    begin
        adj = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    end

    always_comb
    begin
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.shift_bit)
        begin
            digit_next = {adj[dds_pkg::DIGIT_W-2:0], bit_in};
        end
        else if (ctrl.shift_digit)
        begin
            digit_next = digit_in;
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

    assign bit_out = adj[dds_pkg::DIGIT_W-1];
    assign digit   = digit_reg;

endmodule

/* rtl/dds_accum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_accum: digit recombination
// Takes digits most significant first, keeps the leading nonzero digit,
// substitutes the rest and folds them in as acc * 10 + digit.
// ----------------------------------------------------------------------------
module dds_accum #(
    parameter int VALUE_WIDTH = dds_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           clear,
    input  logic                           step,
    input  logic [dds_pkg::DIGIT_W-1:0]    digit_in,
    input  logic [dds_pkg::TABLE_W-1:0]    tbl,
    output logic [VALUE_WIDTH-1:0]         acc
);

    logic                         seen_reg;
    logic                         seen_next;
    logic [VALUE_WIDTH-1:0]       acc_reg;
    logic [VALUE_WIDTH-1:0]       acc_next;
    logic [VALUE_WIDTH-1:0]       acc_x10;
    logic [dds_pkg::DIGIT_W-1:0]  sub_digit;

    always_comb
    begin
        acc_x10   = (acc_reg << 3) + (acc_reg << 1);
        sub_digit = dds_pkg::table_digit(tbl, digit_in);
        seen_next = seen_reg;
        acc_next  = acc_reg;
        if (clear)
        begin
            seen_next = 1'b0;
            acc_next  = '0;
        end
        else if (step)
        begin
            if (seen_reg)
            begin
                acc_next = acc_x10 + VALUE_WIDTH'(sub_digit);
            end
            else if (digit_in != '0)
            begin
                seen_next = 1'b1;
                acc_next  = VALUE_WIDTH'(digit_in);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
            acc_reg  <= '0;
        end
        else
        begin
            seen_reg <= seen_next;
            acc_reg  <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

/* rtl/decimal_digit_substitution.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_digit_substitution: table driven rewrite of decimal digits
// An item transfers on start while busy is low. done is high for one cycle,
// registered from the ST_FIN state that follows the two passes below, and
// result holds until the next done. The magnitude runs one bit per cycle
// through a chain of BCD digit cells, then the digits leave the chain one per
// cycle into a shift-add accumulator; these two passes set the latency. A new
// start is taken in the same cycle that done pulses. The receiver cannot
// stall: result must be taken in the done cycle. Table writes are meant for
// idle periods.
// ----------------------------------------------------------------------------
module decimal_digit_substitution #(
    parameter int VALUE_WIDTH = dds_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [dds_pkg::CFG_INDEX_W-1:0]    wr_index,
    input  logic [dds_pkg::TABLE_W-1:0]        wr_data,
    input  logic                               start,
    output logic                               busy,
    input  logic                               op,
    input  logic signed [dds_pkg::DATA_W-1:0]  value,
    output logic                               done,
    output logic signed [dds_pkg::DATA_W-1:0]  result
);

    localparam int NUM_DIGITS = dds_pkg::digit_count(VALUE_WIDTH);
    localparam int CNT_W      = $clog2(VALUE_WIDTH);

    dds_pkg::state_t             state_reg;
    dds_pkg::state_t             state_next;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic [dds_pkg::TABLE_W-1:0] enc_table_reg;
    logic [dds_pkg::TABLE_W-1:0] dec_table_reg;
    logic                        op_reg;
    logic                        neg_reg;
    logic [VALUE_WIDTH-1:0]      mag_reg;
    logic [VALUE_WIDTH-1:0]      mag_next;
    logic                        done_reg;
    logic                        done_next;
    logic signed [dds_pkg::DATA_W-1:0] result_reg;

    logic                        accept;
    logic [VALUE_WIDTH-1:0]      value_low;
    logic signed [VALUE_WIDTH-1:0] final_val;
    dds_pkg::cell_ctrl_t         cell_ctrl;
    logic                        acc_clear;
    logic                        acc_step;
    logic [VALUE_WIDTH-1:0]      acc;
    logic [dds_pkg::TABLE_W-1:0] tbl_sel;

    logic [dds_pkg::DIGIT_W-1:0] digits [NUM_DIGITS];
    logic                        carry  [NUM_DIGITS];

    assign accept    = start && (state_reg == dds_pkg::ST_IDLE);
    assign value_low = value[VALUE_WIDTH-1:0];
    assign tbl_sel   = (op_reg == dds_pkg::OP_DECODE) ? dec_table_reg : enc_table_reg;

    always_comb
    begin
        mag_next = mag_reg;
        if (accept)
        begin
            mag_next = value_low[VALUE_WIDTH-1] ? (~value_low + 1'b1) : value_low;
        end
        else if (state_reg == dds_pkg::ST_CONV)
        begin
            mag_next = mag_reg << 1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dds_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = dds_pkg::ST_CONV;
                end
            end
            dds_pkg::ST_CONV:
            begin
                if (count_reg == '0)
                begin
                    state_next = dds_pkg::ST_COMB;
                end
            end
            dds_pkg::ST_COMB:
            begin
                if (count_reg == '0)
                begin
                    state_next = dds_pkg::ST_FIN;
                end
            end
            dds_pkg::ST_FIN:
            begin
                state_next = dds_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dds_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cell_ctrl  = '0;
        acc_clear  = 1'b0;
        acc_step   = 1'b0;
        done_next  = 1'b0;
        count_next = count_reg;
        unique case (state_reg)
            dds_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cell_ctrl.clear = 1'b1;
                    acc_clear       = 1'b1;
                    count_next      = CNT_W'(VALUE_WIDTH - 1);
                end
            end
            dds_pkg::ST_CONV:
            begin
                cell_ctrl.shift_bit = 1'b1;
                count_next = (count_reg == '0) ? CNT_W'(NUM_DIGITS - 1) : count_reg - 1'b1;
            end
            dds_pkg::ST_COMB:
            begin
                cell_ctrl.shift_digit = 1'b1;
                acc_step              = 1'b1;
                count_next            = count_reg - 1'b1;
            end
            dds_pkg::ST_FIN:
            begin
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    assign final_val = neg_reg ? signed'(~acc + 1'b1) : signed'(acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dds_pkg::ST_IDLE;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            enc_table_reg <= dds_pkg::TABLE_RESET;
            dec_table_reg <= dds_pkg::TABLE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (wr_en)
            begin
                unique case (wr_index)
                    dds_pkg::REG_ENCODE_TABLE: enc_table_reg <= wr_data;
                    dds_pkg::REG_DECODE_TABLE: dec_table_reg <= wr_data;
                    default:                   enc_table_reg <= enc_table_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        if (accept)
        begin
            op_reg  <= op;
            neg_reg <= value_low[VALUE_WIDTH-1];
        end
        if (state_reg == dds_pkg::ST_FIN)
        begin
            result_reg <= dds_pkg::DATA_W'(final_val);
        end
    end

    genvar k;
    generate
        for (k = 0; k < NUM_DIGITS; k++)
        begin : g_cell
            logic                        cell_bit_in;
            logic [dds_pkg::DIGIT_W-1:0] cell_digit_in;
            if (k == 0)
            begin : g_first
                assign cell_bit_in   = mag_reg[VALUE_WIDTH-1];
                assign cell_digit_in = '0;
            end
            else
            begin : g_rest
                assign cell_bit_in   = carry[k-1];
                assign cell_digit_in = digits[k-1];
            end
            dds_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl),
                .bit_in   (cell_bit_in),
                .bit_out  (carry[k]),
                .digit_in (cell_digit_in),
                .digit    (digits[k])
            );
        end
    endgenerate

    dds_accum #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (acc_clear),
        .step     (acc_step),
        .digit_in (digits[NUM_DIGITS-1]),
        .tbl      (tbl_sel),
        .acc      (acc)
    );

    assign busy   = (state_reg != dds_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
